// ===== design/ego_frame_goal_features_macros.svh =====
// Assertion macros shared by the ego frame goal feature block.
`ifndef EGO_FRAME_GOAL_FEATURES_MACROS_SVH
`define EGO_FRAME_GOAL_FEATURES_MACROS_SVH
`ifndef NO_ASSERTIONS
`define EFGF_ASSERT_IMP(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("efgf assertion failed");
`define EFGF_ASSERT_NXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("efgf assertion failed");
`else
`define EFGF_ASSERT_IMP(label, clk, rst_n, a, b)
`define EFGF_ASSERT_NXT(label, clk, rst_n, a, b)
`endif
`endif

// ===== design/efgf_pkg.sv =====
// Package: types, constants and helper functions of the ego frame goal feature block.
`timescale 1ns / 1ps
package efgf_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ROT_W = 27;
  localparam int VEC_W = 36;
  localparam int ANG_W = 32;
  localparam int Q_BITS = 16;
  localparam int REM_W = 33;
  localparam int ADDR_W = 2;
  localparam logic [ADDR_W-1:0] ADDR_RANGE_MAX = 2'd0;
  localparam logic [15:0] RANGE_RESET = 16'd10000;
  localparam logic signed [16:0] GAIN_Q16 = 17'sd39797;

  typedef struct packed {
    logic signed [23:0] robot_x_mm;
    logic signed [23:0] robot_y_mm;
    logic signed [15:0] robot_yaw;
    logic signed [15:0] vel_x_world;
    logic signed [15:0] vel_y_world;
    logic signed [15:0] yaw_rate;
    logic signed [23:0] goal_x_mm;
    logic signed [23:0] goal_y_mm;
    logic signed [15:0] bearing_to_goal;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] vel_x_ego;
    logic signed [15:0] vel_y_ego;
    logic signed [15:0] yaw_rate_out;
    logic [15:0]        goal_distance_norm;
    logic signed [15:0] heading_error_norm;
  } out_item_t;

  // One CORDIC lane pair: rotation (velocity) and vectoring (goal offset).
  typedef struct packed {
    logic signed [ROT_W-1:0] rx;
    logic signed [ROT_W-1:0] ry;
    logic signed [ANG_W-1:0] rz;
    logic signed [VEC_W-1:0] vx;
    logic signed [VEC_W-1:0] vy;
    logic [15:0]             yr;
    logic [15:0]             hd;
  } cordic_t;

  typedef struct packed {
    logic signed [43:0] pvx;
    logic signed [43:0] pvy;
    logic [50:0]        pd;
    logic [15:0]        yr;
    logic [15:0]        hd;
  } gain_t;

  typedef struct packed {
    logic [15:0]       vel_x;
    logic [15:0]       vel_y;
    logic [15:0]       yr;
    logic [15:0]       hd;
    logic [Q_BITS-1:0] q;
    logic              sat;
    logic [REM_W-1:0]  rem;
    logic [16:0]       d;
  } div_t;

  function automatic logic [ANG_W-1:0] atan_lut(input logic [4:0] idx);
    logic [ANG_W-1:0] r;
    case (idx)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2F9;
      5'd15: r = 32'h0000517C;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A2F;
      5'd19: r = 32'h00000517;
      5'd20: r = 32'h0000028B;
      5'd21: r = 32'h00000145;
      5'd22: r = 32'h000000A2;
      5'd23: r = 32'h00000051;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Round half up at bit 23, drop 24 bits, clamp to int16.
  function automatic logic [15:0] round_sat16(input logic signed [43:0] p);
    logic signed [43:0] s;
    logic signed [43:0] sh;
    logic [15:0] r;
    s  = p + 44'sd8388608;
    sh = s >>> 24;
    if (sh > 44'sd32767) r = 16'h7FFF;
    else if (sh < -44'sd32768) r = 16'h8000;
    else r = sh[15:0];
    return r;
  endfunction

endpackage

// ===== design/efgf_stream_if.sv =====
// Valid/ready stream interface carrying one payload item.
`timescale 1ns / 1ps
interface efgf_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/ego_frame_goal_features.sv =====
// A request passes the setup, CORDIC, gain, divider setup, divider and output registers.
// Throughput: one request per cycle; the whole pipeline advances together and
// freezes while the output register holds a result that is not taken.
// Depth grows with the CORDIC stages; the restoring divider has 16 stages.
// Reset (rst_n low, synchronous) empties the pipeline and sets range_max_mm to 10000.
`timescale 1ns / 1ps
`include "ego_frame_goal_features_macros.svh"
module ego_frame_goal_features #(
  parameter int CORDIC_STAGES = efgf_pkg::CORDIC_STAGES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  efgf_stream_if.sink                   in_if,
  efgf_stream_if.source                 out_if,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [efgf_pkg::ADDR_W-1:0]   cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready
);

  // ---------------- configuration ----------------
  logic [15:0] range_r;
  logic [15:0] range_nxt;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite
               && (cfg_paddr == efgf_pkg::ADDR_RANGE_MAX);
  assign range_nxt = cfg_wr ? cfg_pwdata[15:0] : range_r;
  assign cfg_prdata = (cfg_paddr == efgf_pkg::ADDR_RANGE_MAX) ? {16'd0, range_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_r <= efgf_pkg::RANGE_RESET;
    end else begin
      range_r <= range_nxt;
    end
  end

  // ---------------- global advance ----------------
  // Every stage moves when the output register is free or being drained.
  logic      en;
  logic      out_valid_r;
  efgf_pkg::out_item_t out_r;

  assign en = !out_valid_r || out_if.ready;
  assign in_if.ready = en;

  // ---------------- stage 0: operand setup ----------------
  // Rotation angle is -yaw; outside +-pi/2 the vector is pre-turned by pi.
  // Vectoring starts from |dx|, dy in Q8 mm.
  logic              v0_r;
  efgf_pkg::cordic_t s0_r;
  efgf_pkg::cordic_t s0_nxt;
  logic [efgf_pkg::ANG_W-1:0] theta;
  logic signed [efgf_pkg::ANG_W-1:0] th_s;
  logic signed [efgf_pkg::ROT_W-1:0] vx0;
  logic signed [efgf_pkg::ROT_W-1:0] vy0;
  logic signed [24:0] gdx;
  logic signed [24:0] gdy;
  logic signed [24:0] gdx_abs;

  always_comb begin
    theta = {16'(-in_if.data.robot_yaw), 16'd0};
    th_s  = $signed(theta);
    vx0   = {{3{in_if.data.vel_x_world[15]}}, in_if.data.vel_x_world, 8'd0};
    vy0   = {{3{in_if.data.vel_y_world[15]}}, in_if.data.vel_y_world, 8'd0};
    gdx   = 25'(in_if.data.goal_x_mm) - 25'(in_if.data.robot_x_mm);
    gdy   = 25'(in_if.data.goal_y_mm) - 25'(in_if.data.robot_y_mm);
    gdx_abs = gdx[24] ? -gdx : gdx;
    s0_nxt.rx = vx0;
    s0_nxt.ry = vy0;
    s0_nxt.rz = th_s;
    if (th_s > 32'sh40000000 || th_s < -32'sh40000000) begin
      s0_nxt.rx = -vx0;
      s0_nxt.ry = -vy0;
      s0_nxt.rz = $signed({~theta[31], theta[30:0]});
    end
    s0_nxt.vx = {{3{gdx_abs[24]}}, gdx_abs, 8'd0};
    s0_nxt.vy = {{3{gdy[24]}}, gdy, 8'd0};
    s0_nxt.yr = in_if.data.yaw_rate;
    // wrapped angle difference is already error / pi in Q1.15
    s0_nxt.hd = in_if.data.bearing_to_goal - in_if.data.robot_yaw;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_r <= s0_nxt;
    end
  end

  // ---------------- CORDIC stages ----------------
  logic              vc;
  efgf_pkg::cordic_t cout;

  efgf_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (v0_r),
    .in_data  (s0_r),
    .out_valid(vc),
    .out_data (cout)
  );

  // ---------------- gain compensation multiply ----------------
  logic            vg_r;
  efgf_pkg::gain_t g_r;
  efgf_pkg::gain_t g_nxt;
  logic [34:0]     xpos;

  always_comb begin
    xpos = cout.vx[efgf_pkg::VEC_W-1] ? 35'd0 : cout.vx[34:0];
    g_nxt.pvx = cout.rx * efgf_pkg::GAIN_Q16;
    g_nxt.pvy = cout.ry * efgf_pkg::GAIN_Q16;
    g_nxt.pd  = xpos * efgf_pkg::GAIN_Q16[15:0];
    g_nxt.yr  = cout.yr;
    g_nxt.hd  = cout.hd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vg_r <= 1'b0;
    end else if (en) begin
      vg_r <= vc;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g_r <= g_nxt;
    end
  end

  // ---------------- rounding and divider setup ----------------
  // q = floor((dist_q8*32 + t) / (2t)), same as rounding dist*4096/(t*256).
  logic            vd_r [17];
  efgf_pkg::div_t  dv_r [17];
  efgf_pkg::div_t  prep_nxt;
  logic [51:0]     dsum;
  logic [34:0]     dist_q8;
  logic [15:0]     rng_t;
  logic [40:0]     num;

  always_comb begin
    dsum    = 52'(g_r.pd) + 52'h8000;
    dist_q8 = dsum[50:16];
    rng_t   = (range_r == 16'd0) ? 16'd1 : range_r;
    num     = {1'b0, dist_q8, 5'd0} + 41'(rng_t);
    prep_nxt.vel_x = efgf_pkg::round_sat16(g_r.pvx);
    prep_nxt.vel_y = efgf_pkg::round_sat16(g_r.pvy);
    prep_nxt.yr    = g_r.yr;
    prep_nxt.hd    = g_r.hd;
    prep_nxt.d     = {rng_t, 1'b0};
    prep_nxt.sat   = num >= {8'd0, rng_t, 1'b0, 16'd0};
    prep_nxt.rem   = num[efgf_pkg::REM_W-1:0];
    prep_nxt.q     = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r[0] <= 1'b0;
    end else if (en) begin
      vd_r[0] <= vg_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_r[0] <= prep_nxt;
    end
  end

  // ---------------- restoring divider, one quotient bit per stage ----------------
  for (genvar k = 0; k < efgf_pkg::Q_BITS; k++) begin : g_div
    localparam int B = efgf_pkg::Q_BITS - 1 - k;
    efgf_pkg::div_t         dn;
    logic [efgf_pkg::REM_W-1:0] dsh;
    logic                   ge;

    always_comb begin
      dsh = efgf_pkg::REM_W'(dv_r[k].d) << B;
      ge  = dv_r[k].rem >= dsh;
      dn  = dv_r[k];
      dn.q[B] = ge;
      if (ge) begin
        dn.rem = dv_r[k].rem - dsh;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vd_r[k+1] <= 1'b0;
      end else if (en) begin
        vd_r[k+1] <= vd_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_r[k+1] <= dn;
      end
    end
  end

  // ---------------- output register ----------------
  efgf_pkg::out_item_t out_nxt;
  efgf_pkg::div_t      dlast;

  always_comb begin
    dlast = dv_r[efgf_pkg::Q_BITS];
    out_nxt.vel_x_ego          = dlast.vel_x;
    out_nxt.vel_y_ego          = dlast.vel_y;
    out_nxt.yaw_rate_out       = dlast.yr;
    out_nxt.goal_distance_norm = dlast.sat ? 16'hFFFF : dlast.q;
    out_nxt.heading_error_norm = dlast.hd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vd_r[efgf_pkg::Q_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_r;

  // ---------------- assertions ----------------
  // divider remainder stays below the divisor once all bits are resolved
  `EFGF_ASSERT_IMP(a_div_rem, clk, rst_n, vd_r[efgf_pkg::Q_BITS] && !dlast.sat, dlast.rem < 33'(dlast.d))
  // an accepted request lands in the setup stage
  `EFGF_ASSERT_NXT(a_in_load, clk, rst_n, in_if.valid && in_if.ready, v0_r)
  // a stalled pipeline keeps its first stage occupancy
  `EFGF_ASSERT_NXT(a_stall_hold, clk, rst_n, !en, $stable(v0_r) && $stable(vg_r))

endmodule

// ===== design/efgf_cordic.sv =====
// Pipelined CORDIC: rotation lane for velocity, vectoring lane for goal offset.
`timescale 1ns / 1ps
module efgf_cordic #(
  parameter int STAGES = efgf_pkg::CORDIC_STAGES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  efgf_pkg::cordic_t in_data,
  output logic              out_valid,
  output efgf_pkg::cordic_t out_data
);

  logic              v_r  [STAGES+1];
  efgf_pkg::cordic_t st_r [STAGES+1];

  always_comb begin
    v_r[0]  = in_valid;
    st_r[0] = in_data;
  end

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    localparam logic [4:0] IDX = 5'(k);
    efgf_pkg::cordic_t cur;
    efgf_pkg::cordic_t st_nxt;
    logic [efgf_pkg::ANG_W-1:0] ang;

    always_comb begin
      cur    = st_r[k];
      ang    = efgf_pkg::atan_lut(IDX);
      st_nxt = cur;
      if (!cur.rz[efgf_pkg::ANG_W-1]) begin
        st_nxt.rx = cur.rx - (cur.ry >>> k);
        st_nxt.ry = cur.ry + (cur.rx >>> k);
        st_nxt.rz = cur.rz - $signed(ang);
      end else begin
        st_nxt.rx = cur.rx + (cur.ry >>> k);
        st_nxt.ry = cur.ry - (cur.rx >>> k);
        st_nxt.rz = cur.rz + $signed(ang);
      end
      if (cur.vy[efgf_pkg::VEC_W-1]) begin
        st_nxt.vx = cur.vx - (cur.vy >>> k);
        st_nxt.vy = cur.vy + (cur.vx >>> k);
      end else begin
        st_nxt.vx = cur.vx + (cur.vy >>> k);
        st_nxt.vy = cur.vy - (cur.vx >>> k);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (en) begin
        v_r[k+1] <= v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_r[k+1] <= st_nxt;
      end
    end
  end

  assign out_valid = v_r[STAGES];
  assign out_data  = st_r[STAGES];

endmodule
